[hdl/psfosp_pkg.sv]
// Shared types, constants and helpers for the outer sidelobe peak block.
`default_nettype none
package psfosp_pkg;

    localparam int MAX_DIM     = 256;
    localparam int SAMPLE_BITS = 18;
    localparam int COORD_W     = 8;
    localparam int DIM_W       = 9;
    localparam int CNT_W       = 17;
    localparam int CFG_W       = 9;
    localparam int IDX_W       = 2;

    localparam logic [IDX_W-1:0] CFG_PLANE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_PLANE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_HALF_WIDTH   = 2'd2;

    localparam logic [DIM_W-1:0]   RST_PLANE_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]   RST_PLANE_HEIGHT = 9'd256;
    localparam logic [COORD_W-1:0] RST_HALF_WIDTH   = 8'd32;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } t_in_word;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sidelobe_level;
        logic [COORD_W-1:0]     peak_x;
        logic [COORD_W-1:0]     peak_y;
    } t_out_word;

    // Excluded window and plane size handed to the rescan unit
    typedef struct packed {
        logic [DIM_W-1:0] xl;
        logic [DIM_W-1:0] xh;
        logic [DIM_W-1:0] yl;
        logic [DIM_W-1:0] yh;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_win;

    typedef struct packed {
        logic                   done;
        logic [SAMPLE_BITS-1:0] level;
    } t_scan_res;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/psfosp_store.sv]
// Plane sample memory: one write port, one read port with registered data.
`default_nettype none
module psfosp_store
    import psfosp_pkg::*;
#(
    parameter int STORE_DEPTH = 65536,
    parameter int ADDR_W      = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [ADDR_W-1:0]             i_wr_addr,
    input  wire logic signed [SAMPLE_BITS-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0]             i_rd_addr,
    output logic signed [SAMPLE_BITS-1:0]      o_rd_data
);

    logic signed [SAMPLE_BITS-1:0] r_mem [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

[hdl/psfosp_outer.sv]
// Rescan unit: walks the stored plane, skips the peak window, tracks max and min.
`default_nettype none
module psfosp_outer
    import psfosp_pkg::*;
#(
    parameter int STORE_DEPTH = 65536,
    parameter int ADDR_W      = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire t_win                          i_win,
    output logic [ADDR_W-1:0]                  o_rd_addr,
    input  wire logic signed [SAMPLE_BITS-1:0] i_rd_data,
    output t_scan_res                          o_res
);

    logic                          r_busy;
    logic [DIM_W-1:0]              r_x;
    logic [DIM_W-1:0]              r_y;
    logic [CNT_W-1:0]              r_addr;
    logic                          r_use;
    logic                          r_fin;
    logic                          r_done;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic signed [SAMPLE_BITS-1:0] r_min;

    logic [31:0]                   addr_ext;
    logic                          in_range;
    logic                          in_win;
    logic                          at_end;
    logic                          row_end;
    logic signed [SAMPLE_BITS:0]   max_ext;
    logic signed [SAMPLE_BITS:0]   neg_min;
    logic signed [SAMPLE_BITS:0]   level;

    assign addr_ext  = 32'(r_addr);
    assign o_rd_addr = addr_ext[ADDR_W-1:0];
    assign in_range  = addr_ext < 32'(STORE_DEPTH);
    assign in_win    = (r_x >= i_win.xl) && (r_x <= i_win.xh)
                    && (r_y >= i_win.yl) && (r_y <= i_win.yh);
    assign row_end   = (r_y == i_win.h - DIM_W'(1));
    assign at_end    = row_end && (r_x == i_win.w - DIM_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_use  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_use  <= r_busy && in_range && !in_win;
            r_fin  <= r_busy && at_end;
            r_done <= r_fin;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && at_end) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Address walk: row fastest, so the store address simply counts up
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= '0;
            r_y    <= '0;
            r_addr <= '0;
        end else if (r_busy) begin
            r_addr <= r_addr + CNT_W'(1);
            if (row_end) begin
                r_y <= '0;
                r_x <= r_x + DIM_W'(1);
            end else begin
                r_y <= r_y + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_max <= '0;
            r_min <= '0;
        end else if (r_use) begin
            if (i_rd_data > r_max) begin
                r_max <= i_rd_data;
            end
            if (i_rd_data < r_min) begin
                r_min <= i_rd_data;
            end
        end
    end

    assign max_ext = (SAMPLE_BITS + 1)'(r_max);
    assign neg_min = -((SAMPLE_BITS + 1)'(r_min));
    assign level   = (max_ext > neg_min) ? max_ext : neg_min;

    assign o_res.done  = r_done;
    assign o_res.level = level[SAMPLE_BITS-1:0];

endmodule
`default_nettype wire

[hdl/psf_outer_sidelobe_peak.sv]
// Top level: plane load with peak search, rescan control and result register.
//
// Input channel: one sample word per accepted cycle (i_in_valid high, o_in_stall
// low), row index fastest, column outer. Each sample in the configured plane is
// written to the store and compared against the running peak; samples past the
// plane or past the store are dropped.
// A word with last_sample set ends the plane. The block then stalls its input,
// passes through a setup state and rescans w*h store entries at one entry per
// cycle; the rescan is bound by the single read port of the store. It then
// drains the read pipeline (store read register, then the max and min
// registers) and forms the level.
// Output channel: one word per plane, held in an output register until
// taken (o_out_valid high, i_out_stall low). Loading of the next plane runs
// while that word waits; a finished rescan waits for the register to free up.
// Configuration is a plain write port, taken at any cycle with i_cfg_we high.
// Reset (synchronous, active low) clears control state and the peak and loads
// the default plane size of 256 x 256 and half-width 32. The store is not
// cleared; entries of the plane are valid once written.
`default_nettype none
module psf_outer_sidelobe_peak
    import psfosp_pkg::*;
#(
    parameter int STORE_DEPTH = 65536
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_word         i_in_word,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_word             o_out_word,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    t_state                        r_state;
    logic [DIM_W-1:0]              r_cfg_w;
    logic [DIM_W-1:0]              r_cfg_h;
    logic [COORD_W-1:0]            r_half;
    logic [DIM_W-1:0]              r_scan_col;
    logic [COORD_W-1:0]            r_scan_row;
    logic signed [SAMPLE_BITS-1:0] r_peak_val;
    logic [COORD_W-1:0]            r_peak_col;
    logic [COORD_W-1:0]            r_peak_row;
    logic                          r_out_valid;
    t_out_word                     r_out_word;
    logic [SAMPLE_BITS-1:0]        r_level;

    t_state                        n_state;
    logic [DIM_W-1:0]              w;
    logic [DIM_W-1:0]              h;
    logic                          in_acc;
    logic                          in_plane;
    logic [2*DIM_W-1:0]            ld_prod;
    logic [2*DIM_W:0]              ld_addr;
    logic [31:0]                   ld_addr_ext;
    logic                          ld_in_range;
    logic                          st_we;
    logic [DIM_W-1:0]              n_row;
    logic                          out_free;
    t_win                          win;
    t_scan_res                     scan_res;
    logic [ADDR_W-1:0]             rd_addr;
    logic signed [SAMPLE_BITS-1:0] rd_data;

    assign w = clamp_dim(r_cfg_w);
    assign h = clamp_dim(r_cfg_h);

    assign o_in_stall = (r_state != ST_LOAD);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign in_plane    = (r_scan_col < w) && (DIM_W'(r_scan_row) < h);
    assign ld_prod     = r_scan_col * h;
    assign ld_addr     = (2*DIM_W+1)'(ld_prod) + (2*DIM_W+1)'(r_scan_row);
    assign ld_addr_ext = 32'(ld_addr);
    assign ld_in_range = ld_addr_ext < 32'(STORE_DEPTH);
    assign st_we       = in_acc && in_plane && ld_in_range;
    assign n_row       = DIM_W'(r_scan_row) + DIM_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_PLANE_WIDTH;
            r_cfg_h <= RST_PLANE_HEIGHT;
            r_half  <= RST_HALF_WIDTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PLANE_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_PLANE_HEIGHT: r_cfg_h <= i_cfg_data;
                CFG_HALF_WIDTH:   r_half  <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Scan position of the load; clear it when the plane ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_col <= '0;
            r_scan_row <= '0;
        end else if (in_acc) begin
            if (i_in_word.last_sample) begin
                r_scan_col <= '0;
                r_scan_row <= '0;
            end else if (in_plane) begin
                if (n_row >= h) begin
                    r_scan_row <= '0;
                    r_scan_col <= r_scan_col + DIM_W'(1);
                end else begin
                    r_scan_row <= n_row[COORD_W-1:0];
                end
            end
        end
    end

    // Keep the first strictly largest sample; drop the peak once the word is out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_val <= '0;
            r_peak_col <= '0;
            r_peak_row <= '0;
        end else if (r_state == ST_DONE && out_free) begin
            r_peak_val <= '0;
            r_peak_col <= '0;
            r_peak_row <= '0;
        end else if (st_we && (i_in_word.sample > r_peak_val)) begin
            r_peak_val <= i_in_word.sample;
            r_peak_col <= r_scan_col[COORD_W-1:0];
            r_peak_row <= r_scan_row;
        end
    end

    // Window bounds, lower edges clamped at zero
    assign win.xl = (r_peak_col > r_half) ? DIM_W'(r_peak_col - r_half) : '0;
    assign win.xh = DIM_W'(r_peak_col) + DIM_W'(r_half);
    assign win.yl = (r_peak_row > r_half) ? DIM_W'(r_peak_row - r_half) : '0;
    assign win.yh = DIM_W'(r_peak_row) + DIM_W'(r_half);
    assign win.w  = w;
    assign win.h  = h;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (in_acc && i_in_word.last_sample) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: n_state = ST_SCAN;
            ST_SCAN: begin
                if (scan_res.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && scan_res.done) begin
            r_level <= scan_res.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_word.sidelobe_level <= r_level;
            r_out_word.peak_x         <= r_peak_col;
            r_out_word.peak_y         <= r_peak_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    psfosp_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (st_we),
        .i_wr_addr (ld_addr_ext[ADDR_W-1:0]),
        .i_wr_data (i_in_word.sample),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    psfosp_outer #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_outer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == ST_SETUP),
        .i_win     (win),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_res     (scan_res)
    );

endmodule
`default_nettype wire

[hdl/psfosp_checker.sv]
// Port-level checks for the outer sidelobe peak block, bound to the top level.
`default_nettype none
module psfosp_props
    import psfosp_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire t_in_word         i_in_word,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire t_out_word        o_out_word
);

    logic in_acc;

    assign in_acc   = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("result word changed while stalled");

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_word.last_sample |=> o_in_stall && !o_out_valid ||
        o_in_stall && $past(o_out_valid))
        else $error("input not held off after end of plane");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.sidelobe_level <= 18'd131072))
        else $error("sidelobe level out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind psf_outer_sidelobe_peak psfosp_props u_psfosp_props (.*);
`default_nettype wire
